// ===== rtl/core/qnse_pkg.sv =====
// Shared types and constants for the Qn scale estimator.
// No dependencies; used by all modules in rtl/core.
package qnse_pkg;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_SORT_WR,
    ST_BS_INIT,
    ST_CNT,
    ST_BS_UPD,
    ST_FACT,
    ST_MUL,
    ST_OUT
  } qnse_state_e;

  typedef struct packed {
    logic load;
    logic sort_start;
    logic sort_step;
    logic bs_init;
    logic cnt_start;
    logic cnt_step;
    logic bs_upd;
    logic fact_start;
    logic mul_step;
    logic done_clear;
  } qnse_cmd_t;

  typedef struct packed {
    logic sort_done;
    logic cnt_done;
    logic bs_done;
    logic fact_done;
    logic mul_done;
  } qnse_sts_t;

  localparam logic [31:0] GainQ24 = 32'd37277296;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusFew = 2'd1;
  localparam logic [1:0] StatusOvf = 2'd2;

  function automatic logic [23:0] small_factor(input logic [3:0] n);
    logic [23:0] f;
    begin
      case (n)
        4'd2: f = 24'd6694109;
        4'd3: f = 24'd16676552;
        4'd4: f = 24'd8589934 ;
        4'd5: f = 24'd14159970;
        4'd6: f = 24'd10250878;
        4'd7: f = 24'd14378074;
        4'd8: f = 24'd11223957;
        4'd9: f = 24'd14629732;
        default: f = 24'd0;
      endcase
      return f;
    end
  endfunction

endpackage

// ===== rtl/core/qnse_ctrl.sv =====
// Controller for the Qn scale estimator.
// Depends on qnse_pkg; drives the datapath by command struct.
module qnse_ctrl
  import qnse_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic      few_i,
  input  logic      out_taken_i,
  input  qnse_sts_t sts_i,
  output qnse_cmd_t cmd_o,
  output logic      load_ok_o,
  output logic      out_valid_o
);

  qnse_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    load_ok_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        load_ok_o = 1'b1;
        cmd_o.load = 1'b1;
        if (start_i) begin
          state_d = ST_SORT_RD;
        end
      end
      ST_SORT_RD: begin
        if (few_i) begin
          state_d = ST_OUT;
        end else begin
          cmd_o.sort_start = 1'b1;
          state_d = ST_SORT_CMP;
        end
      end
      ST_SORT_CMP: begin
        cmd_o.sort_step = 1'b1;
        if (sts_i.sort_done) begin
          state_d = ST_BS_INIT;
        end
      end
      ST_SORT_WR: begin
        state_d = ST_BS_INIT;
      end
      ST_BS_INIT: begin
        cmd_o.bs_init = 1'b1;
        state_d = ST_BS_UPD;
      end
      ST_BS_UPD: begin
        if (sts_i.bs_done) begin
          cmd_o.fact_start = 1'b1;
          state_d = ST_FACT;
        end else begin
          cmd_o.cnt_start = 1'b1;
          state_d = ST_CNT;
        end
      end
      ST_CNT: begin
        cmd_o.cnt_step = 1'b1;
        if (sts_i.cnt_done) begin
          cmd_o.bs_upd = 1'b1;
          state_d = ST_BS_UPD;
        end
      end
      ST_FACT: begin
        if (sts_i.fact_done) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.mul_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_taken_i) begin
          cmd_o.done_clear = 1'b1;
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

endmodule

// ===== rtl/core/qnse_dp.sv =====
// Datapath for the Qn scale estimator: sample memory, insertion sort,
// binary search with pair counting, factor divider and scaling multiply.
// Depends on qnse_pkg.
module qnse_dp
  import qnse_pkg::*;
#(
  parameter int MaxSamples = 64,
  parameter int IdxW = 6,
  parameter int CntW = 7
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  qnse_cmd_t       cmd_i,
  input  logic            in_fire_i,
  input  logic [31:0]     sample_i,
  input  logic            last_i,
  output logic            start_o,
  output logic            few_o,
  output qnse_sts_t       sts_o,
  output logic [33:0]     scale_o,
  output logic [6:0]      count_o,
  output logic [1:0]      status_o
);

  localparam int PairW = 2 * CntW;

  logic [31:0] mem_q [MaxSamples];
  logic [CntW-1:0] fill_q;
  logic ovf_q;
  logic full;

  assign full = (fill_q == CntW'(MaxSamples));
  assign start_o = in_fire_i && last_i;
  assign few_o = (fill_q < CntW'(2));

  always_ff @(posedge clk_i) begin
    if (in_fire_i && !full) begin
      mem_q[fill_q[IdxW-1:0]] <= sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.done_clear) begin
      fill_q <= '0;
      ovf_q <= 1'b0;
    end else if (in_fire_i) begin
      if (full) begin
        ovf_q <= 1'b1;
      end else begin
        fill_q <= fill_q + CntW'(1);
      end
    end
  end

  // Sorted copy built by one insertion step per cycle: the new value
  // moves down while its left neighbor is larger. The left neighbor is
  // kept in a register that is read ahead from the sorted copy.
  logic signed [31:0] srt_q [MaxSamples];
  logic [CntW-1:0] si_q, sj_q;
  logic signed [31:0] sv_q;
  logic signed [31:0] left_q;
  logic sort_done;

  assign sort_done = (si_q == fill_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sort_start) begin
      si_q <= CntW'(1);
      sj_q <= CntW'(1);
      sv_q <= mem_q[1];
      left_q <= mem_q[0];
      srt_q[0] <= mem_q[0];
    end else if (cmd_i.sort_step && !sort_done) begin
      if (sj_q != '0 && left_q > sv_q) begin
        srt_q[sj_q[IdxW-1:0]] <= left_q;
        sj_q <= sj_q - CntW'(1);
        left_q <= srt_q[IdxW'(sj_q - CntW'(2))];
      end else begin
        srt_q[sj_q[IdxW-1:0]] <= sv_q;
        si_q <= si_q + CntW'(1);
        sj_q <= si_q + CntW'(1);
        left_q <= (sj_q == si_q) ? sv_q : srt_q[si_q[IdxW-1:0]];
        if (si_q + CntW'(1) < CntW'(MaxSamples)) begin
          sv_q <= mem_q[IdxW'(si_q + CntW'(1))];
        end
      end
    end
  end

  // Binary search over difference values; each probe counts pairs with a
  // two-pointer sweep, one pointer move per cycle.
  logic [32:0] lo_q, hi_q, mid;
  logic [CntW-1:0] ci_q, cj_q;
  logic [PairW-1:0] cnt_q, k_q;
  logic signed [31:0] vi_q, vj_q;
  logic cnt_done;
  logic signed [32:0] diff;
  logic [CntW-1:0] h;

  assign mid = lo_q + ((hi_q - lo_q) >> 1);
  assign h = (fill_q >> 1) + CntW'(1);
  assign diff = 33'(vj_q) - 33'(vi_q);
  assign cnt_done = (cj_q == fill_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.bs_init) begin
      lo_q <= '0;
      hi_q <= 33'h0_FFFF_FFFF;
      k_q <= PairW'((PairW'(h) * PairW'(h - CntW'(1))) >> 1);
    end else if (cmd_i.bs_upd) begin
      if (cnt_q >= k_q) begin
        hi_q <= mid;
      end else begin
        lo_q <= mid + 33'd1;
      end
    end
    if (cmd_i.cnt_start) begin
      ci_q <= '0;
      cj_q <= '0;
      cnt_q <= '0;
      vi_q <= srt_q[0];
      vj_q <= srt_q[0];
    end else if (cmd_i.cnt_step && !cnt_done) begin
      if (diff > $signed(mid)) begin
        ci_q <= ci_q + CntW'(1);
        vi_q <= srt_q[IdxW'(ci_q + CntW'(1))];
      end else begin
        cnt_q <= cnt_q + PairW'(cj_q - ci_q);
        cj_q <= cj_q + CntW'(1);
        vj_q <= srt_q[IdxW'(cj_q + CntW'(1))];
      end
    end
  end

  // Factor: restoring division (10n << 24) / (10n + c), one bit a cycle.
  logic [23:0] fac_q;
  logic [CntW+3:0] den_q;
  logic [CntW+4:0] rem_q;
  logic [CntW+27:0] num_q;
  logic [5:0] fbit_q;
  logic fbusy_q;
  logic [CntW+3:0] tn;
  logic [CntW+4:0] rsh;

  assign tn = (CntW+4)'(fill_q) * (CntW+4)'(10);
  assign rsh = {rem_q[CntW+3:0], num_q[CntW+27]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fbusy_q <= 1'b0;
    end else if (cmd_i.fact_start) begin
      fbusy_q <= (fill_q > CntW'(9));
    end else if (fbusy_q && fbit_q == 6'd0) begin
      fbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fact_start) begin
      fac_q <= small_factor(4'(fill_q));
      den_q <= tn + (fill_q[0] ? (CntW+4)'(14) : (CntW+4)'(38));
      num_q <= {tn, 24'd0};
      rem_q <= '0;
      fbit_q <= 6'(CntW + 27);
    end else if (fbusy_q) begin
      num_q <= num_q << 1;
      fbit_q <= fbit_q - 6'd1;
      if (rsh >= {1'b0, den_q}) begin
        rem_q <= rsh - {1'b0, den_q};
        fac_q <= {fac_q[22:0], 1'b1};
      end else begin
        rem_q <= rsh;
        fac_q <= {fac_q[22:0], 1'b0};
      end
    end
  end

  // Scale: q*G, registered, then (th*cf + (tl*cf >> 24)) >> 24.
  logic [1:0] mstep_q;
  logic [63:0] t_q;
  logic [63:0] p1_q;
  logic [47:0] p2_q;
  logic [64:0] sum;

  assign sum = {1'b0, p1_q} + 65'(p2_q >> 24);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mstep_q <= '0;
    end else if (cmd_i.mul_step) begin
      mstep_q <= (mstep_q == 2'd2) ? 2'd0 : mstep_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_step) begin
      case (mstep_q)
        2'd0: t_q <= 64'(lo_q[31:0]) * 64'(GainQ24);
        2'd1: begin
          p1_q <= 64'(t_q[63:24]) * 64'(fac_q);
          p2_q <= 48'(t_q[23:0]) * 48'(fac_q);
        end
        default: ;
      endcase
    end
  end

  assign scale_o = few_o ? 34'd0 : sum[57:24];
  assign count_o = 7'(fill_q);
  assign status_o = few_o ? StatusFew : (ovf_q ? StatusOvf : StatusOk);

  assign sts_o.sort_done = sort_done;
  assign sts_o.cnt_done = cnt_done;
  assign sts_o.bs_done = (lo_q >= hi_q);
  assign sts_o.fact_done = !fbusy_q;
  assign sts_o.mul_done = (mstep_q == 2'd2);

endmodule

// ===== rtl/core/qn_scale_estimator.sv =====
// Top level of the Qn robust scale estimator.
// Instantiates qnse_ctrl and qnse_dp; depends on qnse_pkg.
//
// Samples enter on the s_axis channel, one transfer per cycle, tdata the
// signed Q16.16 sample and tlast marking the final sample of a set.
// Samples beyond MAX_SAMPLES are dropped and flagged in the status.
// After the last transfer the block sorts the set (insertion, one move a
// cycle), runs a 32-step binary search whose probes each count pairs,
// takes the small-sample factor from a table up to nine samples or else
// divides for it, then multiplies. Sets of fewer than two samples go
// straight to the result.
// While computing, s_axis_tready is low. The single result is held on
// m_axis (tdata: scale [33:0], sample_count [40:34], status [42:41])
// until taken; a stalled receiver simply holds the block in that state.
// Reset empties the store and returns to loading.
module qn_scale_estimator
  import qnse_pkg::*;
#(
  parameter int MAX_SAMPLES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // sample [31:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // scale, sample_count, status, zeros
);

  localparam int IdxW = (MAX_SAMPLES > 2) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CntW = $clog2(MAX_SAMPLES + 1);

  qnse_cmd_t cmd;
  qnse_sts_t sts;
  logic in_fire, start, few, load_ok;
  logic [33:0] scale;
  logic [6:0] count;
  logic [1:0] status;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = load_ok;

  qnse_ctrl u_ctrl (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start_i(start),
    .few_i(few),
    .out_taken_i(m_axis_tready),
    .sts_i(sts),
    .cmd_o(cmd),
    .load_ok_o(load_ok),
    .out_valid_o(m_axis_tvalid)
  );

  qnse_dp #(
    .MaxSamples(MAX_SAMPLES),
    .IdxW(IdxW),
    .CntW(CntW)
  ) u_dp (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cmd_i(cmd),
    .in_fire_i(in_fire),
    .sample_i(s_axis_tdata),
    .last_i(s_axis_tlast),
    .start_o(start),
    .few_o(few),
    .sts_o(sts),
    .scale_o(scale),
    .count_o(count),
    .status_o(status)
  );

  assign m_axis_tdata = {5'd0, status, count, scale};

  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input accepted while result pending");

  a_status_few: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[40:34] < 7'd2) |-> (m_axis_tdata[42:41] == StatusFew))
    else $error("short set without error status");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready) |=> s_axis_tready)
    else $error("not back to loading after result");

endmodule
